/* rtl/core/tqm_pkg.sv */
// ----------------------------------------------------------------------------
// Timer queue manager package
// Shared field widths, item kinds, result status codes, the control
// interface between sequencer and datapath, and saturating time addition.
// ----------------------------------------------------------------------------
package tqm_pkg;

   // Field widths
   localparam int TIME_W   = 48;
   localparam int PERIOD_W = 32;
   localparam int ID_W     = 4;
   localparam int KIND_W   = 2;
   localparam int STATUS_W = 3;
   localparam int DELAY_W  = 32;

   // Item kinds
   localparam logic [KIND_W-1:0] KIND_ONESHOT  = 2'd0;
   localparam logic [KIND_W-1:0] KIND_PERIODIC = 2'd1;
   localparam logic [KIND_W-1:0] KIND_CANCEL   = 2'd2;
   localparam logic [KIND_W-1:0] KIND_TICK     = 2'd3;

   // Result status codes
   localparam logic [STATUS_W-1:0] ST_ARMED     = 3'd0;
   localparam logic [STATUS_W-1:0] ST_FULL      = 3'd1;
   localparam logic [STATUS_W-1:0] ST_CANCELLED = 3'd2;
   localparam logic [STATUS_W-1:0] ST_NOT_FOUND = 3'd3;
   localparam logic [STATUS_W-1:0] ST_FIRED     = 3'd4;
   localparam logic [STATUS_W-1:0] ST_IDLE_TICK = 3'd5;

   // Delay codes
   localparam logic [DELAY_W-1:0] DELAY_EMPTY = 32'hFFFF_FFFF;
   localparam logic [DELAY_W-1:0] DELAY_MAX   = 32'h7FFF_FFFF;

   // Commands from the sequencer to the datapath
   typedef struct packed {
      logic load;      // capture the input item
      logic act;       // perform arm or cancel, start a scan
      logic scan;      // examine one slot
      logic apply;     // fire the earliest timer, start a scan
      logic emit;      // load the result register
      logic fire_rsp;  // the result reports a fire
      logic last;      // the result ends the item
   } ctrl_cmd_type;

   // Status from the datapath to the sequencer
   typedef struct packed {
      logic is_tick;   // the held item is a tick
      logic due;       // the earliest timer has expired
      logic scan_done; // the scan is on its final slot
      logic out_free;  // the result register can take a value
   } dp_status_type;

   // Time addition that saturates at the largest time value
   function automatic logic [TIME_W-1:0] sat_add(input logic [TIME_W-1:0]   base,
                                                 input logic [PERIOD_W-1:0] inc);
      logic [TIME_W:0] sum;
      sum = {1'b0, base} + {{(TIME_W + 1 - PERIOD_W){1'b0}}, inc};
      if (sum[TIME_W]) begin
         return {TIME_W{1'b1}};
      end
      return sum[TIME_W-1:0];
   endfunction

endpackage

/* rtl/core/timer_queue_manager.sv */
// ----------------------------------------------------------------------------
// Timer queue manager
// Slot table of one-shot and periodic timers with arm, cancel and tick
// processing, every result reporting the delay to the earliest expiry.
// ----------------------------------------------------------------------------
// For an arm or cancel item, the sequencer performs the action, examines one slot
// of the table per cycle to find the earliest expiry, and then loads the result
// register, which raises rsp_tvalid. The next input transfer can follow once the
// item's final result is loaded. A tick does the same, and for each timer it fires
// it applies the fire, rescans the whole table to report the next delay and to
// find the next due timer, and decides the result. A result the receiver does not
// take stalls the sequencer before it loads the next result. The result register
// lets the next item's input transfer happen while the final result of the
// previous item still waits.
module timer_queue_manager #(
   parameter int MAX_TIMERS = 16,  // 1 to 16, ids are four bits
   parameter int FIRE_LIMIT = 16   // 1 to 64
) (
   input  logic         clock,
   input  logic         reset,
   // Input items
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [135:0] req_tdata,  // now_ms[47:0], when_ms[95:48],
                                    // interval_ms[127:96], target_id[131:128], zeros
   input  logic [1:0]   req_tuser,  // kind[1:0]
   // Results
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [39:0]  rsp_tdata,  // status[2:0], timer_id[6:3],
                                    // next_delay_ms[38:7], zero
   output logic         rsp_tlast
);
   import tqm_pkg::*;

   ctrl_cmd_type          cmd;
   dp_status_type         sts;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ID_W-1:0]       rsp_id;
   logic [DELAY_W-1:0]    rsp_delay;

   // Sequencer
   tqm_ctrl #(
      .FIRE_LIMIT (FIRE_LIMIT)
   ) u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .sts        (sts),
      .cmd        (cmd)
   );

   // Datapath
   tqm_dpath #(
      .MAX_TIMERS (MAX_TIMERS)
   ) u_dpath (
      .clock         (clock),
      .reset         (reset),
      .item_kind     (req_tuser),
      .item_now      (req_tdata[47:0]),
      .item_when     (req_tdata[95:48]),
      .item_interval (req_tdata[127:96]),
      .item_target   (req_tdata[131:128]),
      .cmd           (cmd),
      .sts           (sts),
      .rsp_valid     (rsp_tvalid),
      .rsp_ready     (rsp_tready),
      .rsp_status    (rsp_status),
      .rsp_id        (rsp_id),
      .rsp_delay     (rsp_delay),
      .rsp_last      (rsp_tlast)
   );

   // Result packing
   assign rsp_tdata = {1'b0, rsp_delay, rsp_id, rsp_status};

endmodule

/* rtl/core/tqm_ctrl.sv */
// ----------------------------------------------------------------------------
// Timer queue manager sequencer
// Steps each item through its action, the slot scan, result transfers and
// the fire loop of a tick, and counts fires against the per-tick cap.
// ----------------------------------------------------------------------------
module tqm_ctrl #(
   parameter int FIRE_LIMIT = 16
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_tvalid,
   output logic                  req_tready,
   input  tqm_pkg::dp_status_type sts,
   output tqm_pkg::ctrl_cmd_type  cmd
);
   import tqm_pkg::*;

   localparam int CNT_W = $clog2(FIRE_LIMIT + 1);

   localparam logic [2:0] S_IDLE  = 3'd0;
   localparam logic [2:0] S_ACT   = 3'd1;
   localparam logic [2:0] S_SCAN  = 3'd2;
   localparam logic [2:0] S_EMIT  = 3'd3;
   localparam logic [2:0] S_APPLY = 3'd4;

   logic [2:0]       state_ff, state_in;
   logic [CNT_W-1:0] fire_cnt_ff, fire_cnt_in;
   logic             fired_any;
   logic             cap_hit;

   assign fired_any  = (fire_cnt_ff != '0);
   assign cap_hit    = (fire_cnt_ff == CNT_W'(FIRE_LIMIT));
   assign req_tready = (state_ff == S_IDLE);

   // Next state and commands
   always_comb begin
      state_in     = state_ff;
      cmd          = '0;
      cmd.fire_rsp = fired_any;
      cmd.last     = !fired_any || cap_hit || !sts.due;
      case (state_ff)
         S_IDLE: begin
            cmd.load = req_tvalid;
            if (req_tvalid) begin
               state_in = S_ACT;
            end
         end
         S_ACT: begin
            cmd.act  = 1'b1;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan = 1'b1;
            if (sts.scan_done) begin
               state_in = S_EMIT;
            end
         end
         S_EMIT: begin
            if (sts.is_tick && !fired_any && sts.due) begin
               // The first due timer of a tick fires before any transfer.
               state_in = S_APPLY;
            end else if (sts.out_free) begin
               cmd.emit = 1'b1;
               state_in = cmd.last ? S_IDLE : S_APPLY;
            end
         end
         S_APPLY: begin
            cmd.apply = 1'b1;
            state_in  = S_SCAN;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   // Fire counter for the current tick
   always_comb begin
      fire_cnt_in = fire_cnt_ff;
      if (cmd.load) begin
         fire_cnt_in = '0;
      end else if (cmd.apply) begin
         fire_cnt_in = fire_cnt_ff + CNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         fire_cnt_ff <= '0;
      end else begin
         state_ff    <= state_in;
         fire_cnt_ff <= fire_cnt_in;
      end
   end

   // A tick never fires more timers than the cap allows.
   a_fire_cap: assert property (@(posedge clock) disable iff (reset)
      fire_cnt_ff <= CNT_W'(FIRE_LIMIT))
      else $error("fire count exceeds the per-tick cap");

   // A fire is applied only to a timer that has expired.
   a_apply_due: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_APPLY) |-> sts.due)
      else $error("fire applied to a timer that is not due");

endmodule

/* rtl/core/tqm_dpath.sv */
// ----------------------------------------------------------------------------
// Timer queue manager datapath
// Holds the slot table, the captured item, the running earliest-expiry scan,
// the delay computation and the result register.
// ----------------------------------------------------------------------------
module tqm_dpath #(
   parameter int MAX_TIMERS = 16
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic [tqm_pkg::KIND_W-1:0]     item_kind,
   input  logic [tqm_pkg::TIME_W-1:0]     item_now,
   input  logic [tqm_pkg::TIME_W-1:0]     item_when,
   input  logic [tqm_pkg::PERIOD_W-1:0]   item_interval,
   input  logic [tqm_pkg::ID_W-1:0]       item_target,
   input  tqm_pkg::ctrl_cmd_type          cmd,
   output tqm_pkg::dp_status_type         sts,
   output logic                           rsp_valid,
   input  logic                           rsp_ready,
   output logic [tqm_pkg::STATUS_W-1:0]   rsp_status,
   output logic [tqm_pkg::ID_W-1:0]       rsp_id,
   output logic [tqm_pkg::DELAY_W-1:0]    rsp_delay,
   output logic                           rsp_last
);
   import tqm_pkg::*;

   localparam int IDX_W = (MAX_TIMERS > 1) ? $clog2(MAX_TIMERS) : 1;

   // Captured item
   logic [KIND_W-1:0]   kind_ff;
   logic [TIME_W-1:0]   now_ff;
   logic [TIME_W-1:0]   when_ff;
   logic [PERIOD_W-1:0] interval_ff;
   logic [ID_W-1:0]     target_ff;

   // Slot table
   logic [MAX_TIMERS-1:0] slot_valid_ff, slot_valid_in;
   logic [TIME_W-1:0]     slot_expiry_ff [MAX_TIMERS];
   logic [PERIOD_W-1:0]   slot_period_ff [MAX_TIMERS];

   // Scan state
   logic [IDX_W-1:0]    scan_idx_ff;
   logic                best_valid_ff;
   logic [IDX_W-1:0]    best_id_ff;
   logic [TIME_W-1:0]   best_exp_ff;
   logic [PERIOD_W-1:0] best_per_ff;
   logic [IDX_W-1:0]    fired_id_ff;

   // Result of the arm or cancel action
   logic [STATUS_W-1:0] op_status_ff;
   logic [ID_W-1:0]     op_id_ff;

   // Result register
   logic                rsp_valid_ff;
   logic [STATUS_W-1:0] rsp_status_ff;
   logic [ID_W-1:0]     rsp_id_ff;
   logic [DELAY_W-1:0]  rsp_delay_ff;
   logic                rsp_last_ff;

   logic                is_arm;
   logic                free_found;
   logic [IDX_W-1:0]    free_idx;
   logic [TIME_W-1:0]   arm_expiry;
   logic [PERIOD_W-1:0] arm_period;
   logic                tgt_in_range;
   logic [IDX_W-1:0]    tgt_idx;
   logic                tgt_hit;
   logic [TIME_W-1:0]   rd_expiry;
   logic [PERIOD_W-1:0] rd_period;
   logic                rd_better;
   logic [TIME_W:0]     diff;
   logic                due;
   logic [DELAY_W-1:0]  delay;
   logic                out_free;

   // Item capture
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff     <= item_kind;
         now_ff      <= item_now;
         when_ff     <= item_when;
         interval_ff <= item_interval;
         target_ff   <= item_target;
      end
   end

   // Lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = MAX_TIMERS - 1; i >= 0; i--) begin
         if (!slot_valid_ff[i]) begin
            free_found = 1'b1;
            free_idx   = IDX_W'(i);
         end
      end
   end

   // Arm values and cancel lookup
   assign is_arm       = (kind_ff == KIND_ONESHOT) || (kind_ff == KIND_PERIODIC);
   assign arm_expiry   = (kind_ff == KIND_ONESHOT) ? when_ff : sat_add(now_ff, interval_ff);
   assign arm_period   = (kind_ff == KIND_ONESHOT) ? '0 : interval_ff;
   assign tgt_in_range = ({1'b0, target_ff} < (ID_W + 1)'(MAX_TIMERS));
   assign tgt_idx      = target_ff[IDX_W-1:0];
   assign tgt_hit      = tgt_in_range && slot_valid_ff[tgt_idx];

   // Valid bits
   always_comb begin
      slot_valid_in = slot_valid_ff;
      if (cmd.act) begin
         if (is_arm && free_found) begin
            slot_valid_in[free_idx] = 1'b1;
         end else if ((kind_ff == KIND_CANCEL) && tgt_hit) begin
            slot_valid_in[tgt_idx] = 1'b0;
         end
      end else if (cmd.apply && (best_per_ff == '0)) begin
         slot_valid_in[best_id_ff] = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         slot_valid_ff <= '0;
      end else begin
         slot_valid_ff <= slot_valid_in;
      end
   end

   // Expiry and period table writes
   always_ff @(posedge clock) begin
      if (cmd.act && is_arm && free_found) begin
         slot_expiry_ff[free_idx] <= arm_expiry;
         slot_period_ff[free_idx] <= arm_period;
      end else if (cmd.apply && (best_per_ff != '0)) begin
         slot_expiry_ff[best_id_ff] <= sat_add(best_exp_ff, best_per_ff);
      end
   end

   // Action result
   always_ff @(posedge clock) begin
      if (cmd.act) begin
         if (is_arm) begin
            op_status_ff <= free_found ? ST_ARMED : ST_FULL;
            op_id_ff     <= free_found ? ID_W'(free_idx) : '0;
         end else begin
            op_status_ff <= tgt_hit ? ST_CANCELLED : ST_NOT_FOUND;
            op_id_ff     <= target_ff;
         end
      end
   end

   // Earliest-expiry scan, one slot per cycle, lower id wins ties
   assign rd_expiry = slot_expiry_ff[scan_idx_ff];
   assign rd_period = slot_period_ff[scan_idx_ff];
   assign rd_better = slot_valid_ff[scan_idx_ff] && (!best_valid_ff || (rd_expiry < best_exp_ff));

   always_ff @(posedge clock) begin
      if (reset) begin
         scan_idx_ff   <= '0;
         best_valid_ff <= 1'b0;
      end else if (cmd.act || cmd.apply) begin
         scan_idx_ff   <= '0;
         best_valid_ff <= 1'b0;
      end else if (cmd.scan) begin
         scan_idx_ff <= scan_idx_ff + IDX_W'(1);
         if (rd_better) begin
            best_valid_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.scan && rd_better) begin
         best_id_ff  <= scan_idx_ff;
         best_exp_ff <= rd_expiry;
         best_per_ff <= rd_period;
      end
      if (cmd.apply) begin
         fired_id_ff <= best_id_ff;
      end
   end

   // Delay to the earliest expiry
   assign diff = {1'b0, best_exp_ff} - {1'b0, now_ff};
   assign due  = best_valid_ff && (best_exp_ff <= now_ff);

   always_comb begin
      if (!best_valid_ff) begin
         delay = DELAY_EMPTY;
      end else if (due) begin
         delay = '0;
      end else if (diff[TIME_W-1:DELAY_W-1] != '0) begin
         delay = DELAY_MAX;
      end else begin
         delay = diff[DELAY_W-1:0];
      end
   end

   // Result register, free when empty or being taken
   assign out_free = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (cmd.emit) begin
         rsp_valid_ff <= 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.emit) begin
         rsp_delay_ff <= delay;
         rsp_last_ff  <= cmd.last;
         if (cmd.fire_rsp) begin
            rsp_status_ff <= ST_FIRED;
            rsp_id_ff     <= ID_W'(fired_id_ff);
         end else if (kind_ff == KIND_TICK) begin
            rsp_status_ff <= ST_IDLE_TICK;
            rsp_id_ff     <= '0;
         end else begin
            rsp_status_ff <= op_status_ff;
            rsp_id_ff     <= op_id_ff;
         end
      end
   end

   assign sts.is_tick   = (kind_ff == KIND_TICK);
   assign sts.due       = due;
   assign sts.scan_done = (scan_idx_ff == IDX_W'(MAX_TIMERS - 1));
   assign sts.out_free  = out_free;

   assign rsp_valid  = rsp_valid_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_id     = rsp_id_ff;
   assign rsp_delay  = rsp_delay_ff;
   assign rsp_last   = rsp_last_ff;

   // The result register is loaded only when it can take a value.
   a_emit_free: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> out_free)
      else $error("result loaded while a previous one is still held");

   // An arm into a free slot adds exactly one armed timer.
   a_arm_count: assert property (@(posedge clock) disable iff (reset)
      (cmd.act && is_arm && free_found) |=>
         ($countones(slot_valid_ff) == $countones($past(slot_valid_ff)) + 1))
      else $error("arm did not add exactly one timer");

endmodule
